FILE: sv/swp_pkg.sv
// Shared types and constants of the sliding-window packet sender.
package swp_pkg;

   localparam int STORE_PACKETS = 32;
   localparam int IDX_W         = 5;
   localparam int CNT_W         = $clog2(STORE_PACKETS + 1);
   localparam int PKT_BYTES     = 7;
   localparam int LAST_BYTE     = PKT_BYTES - 1;
   localparam int BYTE_W        = $clog2(PKT_BYTES);
   localparam int BURST_PACKETS = 9;
   localparam int BURST_W       = $clog2(BURST_PACKETS + 1);
   localparam int CHAR_W        = 16;
   localparam int ACK_W         = 8;
   localparam int ACK_IDX_W     = 6;
   localparam int DUP_DEPTH     = 37;
   localparam int DUP_W         = 2;
   // ack / 7 == (ack * 293) >> 11 for every 8-bit ack
   localparam int ACK_RECIP     = 293;
   localparam int ACK_SHIFT     = 11;
   localparam int ACK_PROD_W    = 17;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

   localparam logic [IDX_W-1:0] INIT_WINDOW_END_RESET = IDX_W'(3);

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_START   = 2'd1,
      OP_ACK     = 2'd2,
      OP_TIMEOUT = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      EV_STORED       = 3'd0,
      EV_SENT         = 3'd1,
      EV_ADVANCED     = 3'd2,
      EV_DUP_REPORTED = 3'd3,
      EV_DUP_SILENT   = 3'd4,
      EV_TIMEOUT      = 3'd5,
      EV_FULL         = 3'd6,
      EV_IDLE         = 3'd7
   } ev_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DUP,
      ST_READ,
      ST_BYTE
   } state_type;

   typedef struct packed {
      op_type                 op;
      logic [CHAR_W-1:0]      char_first;
      logic [CHAR_W-1:0]      char_second;
      logic [ACK_IDX_W-1:0]   ack_idx;
   } cmd_type;

   typedef struct packed {
      logic [7:0]       out_byte;
      logic             byte_valid;
      logic             last;
      ev_type           event_res;
      logic [IDX_W-1:0] packet_number;
   } rsp_type;

endpackage

FILE: sv/sliding_window_packet_sender.sv
// Top level of the sliding-window packet sender.
//
// Requests arrive on the req_ valid/ready channel: load (two characters make
// a 7-byte packet), start (send the initial window), ack and timeout. Each
// beat is decoded by the front end and held in a two-entry queue, so the
// sender takes new beats while the sequencer is still busy.
// Results leave on the rsp_ valid/ready channel through an output register;
// rsp_last marks the final result beat of each request.
// csr_wr_en/csr_wr_data write the initial window end; write it only while idle.
// From an idle sequencer, a taken request is held in the command register and
// classified in the execute state: a one-result request is answered from there,
// a duplicate ack after its counter read, a packet after its store read.
// The sequencer handles one request at a time; a sent packet takes one store read
// and seven byte beats; an in-order ack sends one packet and a start up to 9.
// The packet store has one read and one write port; the read port serves the
// per-packet read state.
// Reset clears the window, packet count, duplicate counters and the output;
// it takes effect at once with no clearing pass. A stalled receiver holds the
// output register, the sequencer waits, and the queue fills before req_ready drops.
module sliding_window_packet_sender import swp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [IDX_W-1:0]  csr_wr_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_kind,
   input  logic [CHAR_W-1:0] req_char_first,
   input  logic [CHAR_W-1:0] req_char_second,
   input  logic [ACK_W-1:0]  req_ack_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_byte_valid,
   output logic              rsp_last,
   output logic [2:0]        rsp_event_res,
   output logic [IDX_W-1:0]  rsp_packet_number
);

   logic    push_valid, push_ready, pop_valid, pop_ready;
   cmd_type push_data, pop_data;
   rsp_type rsp_data;

   swp_front u_front (
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_char_first  (req_char_first),
      .req_char_second (req_char_second),
      .req_ack_byte    (req_ack_byte),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_data       (push_data)
   );

   swp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   swp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd_valid   (pop_valid),
      .cmd_ready   (pop_ready),
      .cmd_data    (pop_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   assign rsp_out_byte      = rsp_data.out_byte;
   assign rsp_byte_valid    = rsp_data.byte_valid;
   assign rsp_last          = rsp_data.last;
   assign rsp_event_res     = rsp_data.event_res;
   assign rsp_packet_number = rsp_data.packet_number;

endmodule

FILE: sv/swp_front.sv
// Front end: takes request beats, decodes the kind and turns the ack byte into a packet index.
module swp_front import swp_pkg::*; (
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_kind,
   input  logic [CHAR_W-1:0] req_char_first,
   input  logic [CHAR_W-1:0] req_char_second,
   input  logic [ACK_W-1:0]  req_ack_byte,
   output logic              push_valid,
   input  logic              push_ready,
   output cmd_type           push_data
);

   logic [ACK_PROD_W-1:0] ack_prod;

   // divide by seven through the reciprocal
   assign ack_prod = ACK_PROD_W'(req_ack_byte) * ACK_PROD_W'(ACK_RECIP);

   assign req_ready              = push_ready;
   assign push_valid             = req_valid;
   assign push_data.op           = op_type'(req_kind);
   assign push_data.char_first   = req_char_first;
   assign push_data.char_second  = req_char_second;
   assign push_data.ack_idx      = ACK_IDX_W'(ack_prod >> ACK_SHIFT);

endmodule

FILE: sv/swp_queue.sv
// Short command queue between the front end and the sequencer.
module swp_queue import swp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_data
);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              push, pop;

   assign push_ready = cnt_ff != QCNT_W'(QUEUE_DEPTH);
   assign pop_valid  = cnt_ff != '0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: sv/swp_back.sv
// Sequencer: holds the window state and packet store, and plays out result beats.
module swp_back import swp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [IDX_W-1:0] csr_wr_data,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  cmd_type          cmd_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data
);

   logic [IDX_W-1:0]     init_end_ff;
   state_type            state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [IDX_W-1:0]     ws_ff, ws_in;
   logic [IDX_W-1:0]     we_ff, we_in;
   logic                 sending_ff, sending_in;
   logic [IDX_W-1:0]     cur_ff, cur_in;
   logic [IDX_W-1:0]     hi_ff, hi_in;
   logic [BURST_W-1:0]   done_ff, done_in;
   logic [BYTE_W-1:0]    byte_ff, byte_in;
   ev_type               ev_ff, ev_in;
   logic [DUP_DEPTH-1:0] dup_vld_ff, dup_vld_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic [2*CHAR_W-1:0]  store_mem [STORE_PACKETS];
   logic [2*CHAR_W-1:0]  store_rd_ff;
   logic                 store_we, store_rd_en;
   logic [DUP_W-1:0]     dup_mem [DUP_DEPTH];
   logic [DUP_W-1:0]     dup_rd_ff;
   logic                 dup_we, dup_rd_en;

   logic                 out_free, full, ack_hit, more;
   logic [IDX_W-1:0]     final_idx, start_hi, ws_next, we_next;
   logic [IDX_W:0]       ws_inc, we_inc, final_x;
   logic [DUP_W-1:0]     dup_before, dup_next;
   logic [CHAR_W:0]      sum_raw;
   logic [CHAR_W-1:0]    csum;
   logic [7:0]           seq_byte, pkt_byte;
   logic                 ex_send, ex_dup;
   ev_type               ex_ev;
   logic [IDX_W-1:0]     ex_pn;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign final_idx  = (count_ff == '0) ? '0 : IDX_W'(count_ff - 1'b1);
   assign full       = count_ff >= CNT_W'(STORE_PACKETS);
   assign start_hi   = (init_end_ff < final_idx) ? init_end_ff : final_idx;
   assign final_x    = {1'b0, final_idx};
   assign ws_inc     = {1'b0, ws_ff} + 1'b1;
   assign we_inc     = {1'b0, we_ff} + 1'b1;
   // clamp both window edges at the final packet
   assign ws_next    = (ws_inc > final_x) ? final_idx : ws_inc[IDX_W-1:0];
   assign we_next    = (we_inc > final_x) ? final_idx : we_inc[IDX_W-1:0];
   assign ack_hit    = cmd_ff.ack_idx == ACK_IDX_W'(ws_ff);
   assign dup_before = dup_vld_ff[cmd_ff.ack_idx] ? dup_rd_ff : '0;
   assign dup_next   = (dup_before == '1) ? dup_before : dup_before + 1'b1;
   assign more       = (cur_ff < hi_ff) &&
                       (BURST_W'(done_ff + 1'b1) < BURST_W'(BURST_PACKETS));

   // end-around carry checksum is rebuilt from the stored characters; the sequence byte is the packet index times seven
   assign sum_raw  = {1'b0, store_rd_ff[2*CHAR_W-1:CHAR_W]} + {1'b0, store_rd_ff[CHAR_W-1:0]};
   assign csum     = sum_raw[CHAR_W-1:0] + CHAR_W'(sum_raw[CHAR_W]);
   assign seq_byte = 8'({3'b000, cur_ff} * 8'(PKT_BYTES));

   always_comb begin
      case (byte_ff)
         3'd0:    pkt_byte = store_rd_ff[31:24];
         3'd1:    pkt_byte = store_rd_ff[23:16];
         3'd2:    pkt_byte = store_rd_ff[15:8];
         3'd3:    pkt_byte = store_rd_ff[7:0];
         3'd4:    pkt_byte = csum[15:8];
         3'd5:    pkt_byte = csum[7:0];
         3'd6:    pkt_byte = seq_byte;
         default: pkt_byte = '0;
      endcase
   end

   // classify the held command against the current window
   always_comb begin
      ex_send   = 1'b0;
      ex_dup    = 1'b0;
      ex_ev     = EV_IDLE;
      ex_pn     = '0;
      case (cmd_ff.op)
         OP_LOAD: begin
            if (full) begin
               ex_ev = EV_FULL;
            end else begin
               ex_ev = EV_STORED;
               ex_pn = count_ff[IDX_W-1:0];
            end
         end
         OP_START: begin
            if (!sending_ff && count_ff != '0 && ws_ff < init_end_ff && ws_ff <= start_hi) begin
               ex_send = 1'b1;
            end
         end
         OP_ACK: begin
            if (sending_ff) begin
               if (ack_hit) begin
                  ex_send = 1'b1;
               end else begin
                  ex_dup = 1'b1;
               end
            end
         end
         OP_TIMEOUT: begin
            if (sending_ff) begin
               ex_ev = EV_TIMEOUT;
               ex_pn = ws_ff;
            end
         end
         default: begin
            ex_ev = EV_IDLE;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (ex_send) begin
               state_in = ST_READ;
            end else if (ex_dup) begin
               state_in = ST_DUP;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_DUP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            state_in = ST_BYTE;
         end
         ST_BYTE: begin
            if (out_free && byte_ff == BYTE_W'(LAST_BYTE)) begin
               state_in = more ? ST_READ : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd_ready    = 1'b0;
      cmd_in       = cmd_ff;
      count_in     = count_ff;
      ws_in        = ws_ff;
      we_in        = we_ff;
      sending_in   = sending_ff;
      cur_in       = cur_ff;
      hi_in        = hi_ff;
      done_in      = done_ff;
      byte_in      = byte_ff;
      ev_in        = ev_ff;
      dup_vld_in   = dup_vld_ff;
      store_we     = 1'b0;
      store_rd_en  = 1'b0;
      dup_we       = 1'b0;
      dup_rd_en    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               cmd_in = cmd_data;
            end
         end
         ST_EXEC: begin
            if (ex_send) begin
               done_in = '0;
               if (cmd_ff.op == OP_START) begin
                  we_in      = init_end_ff;
                  sending_in = 1'b1;
                  cur_in     = ws_ff;
                  hi_in      = start_hi;
                  ev_in      = EV_SENT;
               end else begin
                  ws_in      = ws_next;
                  we_in      = we_next;
                  sending_in = ws_next < we_next;
                  cur_in     = we_next;
                  hi_in      = we_next;
                  ev_in      = EV_ADVANCED;
               end
            end else if (ex_dup) begin
               dup_rd_en = 1'b1;
            end else if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in.out_byte      = '0;
               rsp_in.byte_valid    = 1'b0;
               rsp_in.last          = 1'b1;
               rsp_in.event_res     = ex_ev;
               rsp_in.packet_number = ex_pn;
               if (cmd_ff.op == OP_LOAD && !full) begin
                  store_we = 1'b1;
                  count_in = count_ff + 1'b1;
               end
               // start copies the window end even when it finds nothing to send, unless already sending
               if (cmd_ff.op == OP_START && !sending_ff) begin
                  we_in = init_end_ff;
                  if (count_ff != '0 && ws_ff < init_end_ff) begin
                     sending_in = 1'b1;
                  end
               end
            end
         end
         ST_DUP: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in.out_byte      = '0;
               rsp_in.byte_valid    = 1'b0;
               rsp_in.last          = 1'b1;
               rsp_in.event_res     = (dup_before == DUP_W'(1)) ? EV_DUP_REPORTED : EV_DUP_SILENT;
               rsp_in.packet_number = cmd_ff.ack_idx[IDX_W-1:0];
               dup_we                       = 1'b1;
               dup_vld_in[cmd_ff.ack_idx]   = 1'b1;
            end
         end
         ST_READ: begin
            store_rd_en = 1'b1;
            byte_in     = '0;
         end
         ST_BYTE: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in.out_byte      = pkt_byte;
               rsp_in.byte_valid    = 1'b1;
               rsp_in.last          = (byte_ff == BYTE_W'(LAST_BYTE)) && !more;
               rsp_in.event_res     = ev_ff;
               rsp_in.packet_number = cur_ff;
               if (byte_ff == BYTE_W'(LAST_BYTE)) begin
                  if (more) begin
                     cur_in  = cur_ff + 1'b1;
                     done_in = done_ff + 1'b1;
                  end
               end else begin
                  byte_in = byte_ff + 1'b1;
               end
            end
         end
         default: begin
            cmd_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_end_ff  <= INIT_WINDOW_END_RESET;
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ws_ff        <= '0;
         we_ff        <= INIT_WINDOW_END_RESET;
         sending_ff   <= 1'b0;
         dup_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            init_end_ff <= csr_wr_data;
         end
         state_ff     <= state_in;
         count_ff     <= count_in;
         ws_ff        <= ws_in;
         we_ff        <= we_in;
         sending_ff   <= sending_in;
         dup_vld_ff   <= dup_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      cur_ff  <= cur_in;
      hi_ff   <= hi_in;
      done_ff <= done_in;
      byte_ff <= byte_in;
      ev_ff   <= ev_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[count_ff[IDX_W-1:0]] <= {cmd_ff.char_first, cmd_ff.char_second};
      end
      if (store_rd_en) begin
         store_rd_ff <= store_mem[cur_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (dup_we) begin
         dup_mem[cmd_ff.ack_idx] <= dup_next;
      end
      if (dup_rd_en) begin
         dup_rd_ff <= dup_mem[cmd_ff.ack_idx];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_sending_has_packets: assert property (@(posedge clock) disable iff (reset)
      sending_ff |-> count_ff != '0)
      else $error("sending with an empty packet store");

   a_start_inside_store: assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 |-> ws_ff <= final_idx)
      else $error("window start beyond the final packet");

   a_byte_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_BYTE |-> byte_ff <= BYTE_W'(LAST_BYTE))
      else $error("byte counter ran past the packet");

   a_send_reads_stored: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> {1'b0, cur_ff} < count_ff)
      else $error("packet read beyond the stored packets");

endmodule
